[rtl/pscs_pkg.sv]
// Package for the parameter-set start-code scanner.
// Holds register indexes, status codes and the config/result structs.
// No dependencies.
package pscs_pkg;

    localparam int FIELD_W  = 17;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODEC_MODE   = 1'b0,
        CFG_PPS_END_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic codec_mode;
        logic pps_end_mode;
    } t_cfg;

    typedef struct packed {
        t_status              status;
        logic [2:0]           codes_found;
        logic [FIELD_W-1:0]   vps_pos;
        logic [FIELD_W-1:0]   vps_len;
        logic [FIELD_W-1:0]   sps_pos;
        logic [FIELD_W-1:0]   sps_len;
        logic [FIELD_W-1:0]   pps_pos;
        logic [FIELD_W-1:0]   pps_len;
    } t_result;

endpackage

[rtl/pscs_scan.sv]
// Scan state of the start-code scanner: byte counter, match window, unit offsets.
// Computes the result for the current beat combinationally.
// Depends on pscs_pkg.
module pscs_scan #(
    parameter int MAX_BYTES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pscs_pkg::t_cfg     i_cfg,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output pscs_pkg::t_result  o_result
);

    localparam int IDX_W = $clog2(MAX_BYTES + 1);
    localparam int EXT_W = (IDX_W > pscs_pkg::FIELD_W) ? IDX_W : pscs_pkg::FIELD_W;

    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [23:0]      r_recent, n_recent;
    logic [2:0]       r_codes_seen, n_codes_seen;
    logic [IDX_W-1:0] r_vps_start, n_vps_start;
    logic [IDX_W-1:0] r_vps_len, n_vps_len;
    logic [IDX_W-1:0] r_sps_start, n_sps_start;
    logic [IDX_W-1:0] r_sps_len, n_sps_len;
    logic [IDX_W-1:0] r_pps_start, n_pps_start;
    logic [IDX_W-1:0] r_pps_len, n_pps_len;
    logic             r_too_long, n_too_long;

    logic [2:0]       codes_req;
    logic [2:0]       unit;
    logic [IDX_W-1:0] code_pos;
    logic [IDX_W-1:0] payload_pos;
    logic             hit;
    logic [IDX_W-1:0] pps_len_final;

    function automatic logic [pscs_pkg::FIELD_W-1:0] to_field(input logic [IDX_W-1:0] x);
        logic [EXT_W-1:0] t;
        t = EXT_W'(x);
        return t[pscs_pkg::FIELD_W-1:0];
    endfunction

    always_comb begin
        codes_req   = (i_cfg.codec_mode ? 3'd3 : 3'd2) + {2'b00, i_cfg.pps_end_mode};
        unit        = r_codes_seen + (i_cfg.codec_mode ? 3'd0 : 3'd1);
        code_pos    = r_byte_index - IDX_W'(3);
        payload_pos = r_byte_index + IDX_W'(1);
        hit = (r_byte_index >= IDX_W'(3)) && (r_recent == 24'h0) && (i_byte == 8'h01)
              && (r_codes_seen < codes_req);

        n_byte_index = r_byte_index;
        n_recent     = r_recent;
        n_codes_seen = r_codes_seen;
        n_vps_start  = r_vps_start;
        n_vps_len    = r_vps_len;
        n_sps_start  = r_sps_start;
        n_sps_len    = r_sps_len;
        n_pps_start  = r_pps_start;
        n_pps_len    = r_pps_len;
        n_too_long   = r_too_long;

        if (!r_too_long) begin
            if (r_byte_index >= IDX_W'(MAX_BYTES)) begin
                n_too_long = 1'b1;
            end else begin
                if (hit) begin
                    case (unit)
                        3'd0: begin
                            n_vps_start = payload_pos;
                        end
                        3'd1: begin
                            if (i_cfg.codec_mode) begin
                                n_vps_len = code_pos - r_vps_start;
                            end
                            n_sps_start = payload_pos;
                        end
                        3'd2: begin
                            n_sps_len   = code_pos - r_sps_start;
                            n_pps_start = payload_pos;
                        end
                        default: begin
                            n_pps_len = code_pos - r_pps_start;
                        end
                    endcase
                    n_codes_seen = r_codes_seen + 3'd1;
                    n_recent     = 24'hFFFFFF;
                end else begin
                    n_recent = {r_recent[15:0], i_byte};
                end
                n_byte_index = r_byte_index + IDX_W'(1);
            end
        end

        pps_len_final = i_cfg.pps_end_mode ? n_pps_len : (n_byte_index - n_pps_start);

        o_result = '0;
        if (n_too_long) begin
            o_result.status = pscs_pkg::ST_TOO_LONG;
        end else if (n_codes_seen < codes_req) begin
            o_result.status      = pscs_pkg::ST_MISSING;
            o_result.codes_found = n_codes_seen;
        end else begin
            o_result.status      = pscs_pkg::ST_OK;
            o_result.codes_found = n_codes_seen;
            if (i_cfg.codec_mode) begin
                o_result.vps_pos = to_field(n_vps_start);
                o_result.vps_len = to_field(n_vps_len);
            end
            o_result.sps_pos = to_field(n_sps_start);
            o_result.sps_len = to_field(n_sps_len);
            o_result.pps_pos = to_field(n_pps_start);
            o_result.pps_len = to_field(pps_len_final);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_byte_index <= '0;
            r_recent     <= '0;
            r_codes_seen <= '0;
            r_vps_start  <= '0;
            r_vps_len    <= '0;
            r_sps_start  <= '0;
            r_sps_len    <= '0;
            r_pps_start  <= '0;
            r_pps_len    <= '0;
            r_too_long   <= 1'b0;
        end else if (i_step) begin
            r_byte_index <= n_byte_index;
            r_recent     <= n_recent;
            r_codes_seen <= n_codes_seen;
            r_vps_start  <= n_vps_start;
            r_vps_len    <= n_vps_len;
            r_sps_start  <= n_sps_start;
            r_sps_len    <= n_sps_len;
            r_pps_start  <= n_pps_start;
            r_pps_len    <= n_pps_len;
            r_too_long   <= n_too_long;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_byte_index == '0 && r_codes_seen == 3'd0 && !r_too_long)
        else $error("scan state not cleared after last beat");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= IDX_W'(MAX_BYTES))
        else $error("byte index beyond maximum");

    a_codes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_codes_seen <= 3'd4)
        else $error("too many start codes counted");

    a_too_long_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long && i_step && !i_last |=> $stable(r_byte_index) && $stable(r_codes_seen))
        else $error("scan advanced after overflow");
`endif

endmodule

[rtl/parameter_set_start_code_scanner_core.sv]
// Top level of the parameter-set start-code scanner.
// Stream handshake, configuration registers and result register.
// Depends on pscs_pkg and pscs_scan.
//
// Usage:
//   Slave stream carries one buffer byte per beat in tdata[7:0], tlast on the
//   final byte. One byte is taken per clock, except while o_s_tready is low;
//   the scan state updates in a single pass of logic after the accepted beat.
//   On the final byte one result beat appears on the master stream in the
//   next cycle, as the scan state clears for the next buffer. Other bytes
//   produce no result beat.
//   The result register separates the two sides: a new byte is accepted while
//   a result waits, unless that result is still stalled and the incoming byte
//   is itself a final byte; then o_s_tready drops until i_m_tready is high.
//   Configuration (codec mode, PPS end mode) must be written through the write
//   port only while no buffer is in flight; the block does not enforce this.
//   Reset clears the configuration, the scan state and the result valid flag.
//   A buffer longer than MAX_BYTES gives a too-long status.
module parameter_set_start_code_scanner_core #(
    parameter int MAX_BYTES = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [pscs_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic                               i_cfg_wdata,
    // byte stream in
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,  // [7:0] data_byte
    input  logic                               i_s_tlast,  // last_byte
    // result stream out
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [1:0] status, [4:2] codes_found, [21:5] vps_pos, [38:22] vps_len,
    // [55:39] sps_pos, [72:56] sps_len, [89:73] pps_pos, [106:90] pps_len, pad
    output logic [111:0]                       o_m_tdata
);

    pscs_pkg::t_cfg    r_cfg;
    pscs_pkg::t_result scan_result;
    pscs_pkg::t_result r_result;
    logic              r_out_valid;
    logic              s_accept;
    logic              out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = out_free || !i_s_tlast;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (pscs_pkg::t_cfg_idx'(i_cfg_addr))
                pscs_pkg::CFG_CODEC_MODE:   r_cfg.codec_mode   <= i_cfg_wdata;
                pscs_pkg::CFG_PPS_END_MODE: r_cfg.pps_end_mode <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    pscs_scan #(
        .MAX_BYTES (MAX_BYTES)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (s_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_result (scan_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && i_s_tlast) begin
            r_result <= scan_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000,
                         r_result.pps_len, r_result.pps_pos,
                         r_result.sps_len, r_result.sps_pos,
                         r_result.vps_len, r_result.vps_pos,
                         r_result.codes_found, r_result.status};

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_accept && i_s_tlast))
        else $error("result beat without a final input byte");

    a_too_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_result.status == pscs_pkg::ST_TOO_LONG |->
        r_result.codes_found == 3'd0 && r_result.sps_pos == '0 && r_result.pps_len == '0)
        else $error("too-long result carries nonzero fields");

    a_ok_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_result.status == pscs_pkg::ST_OK |-> r_result.codes_found >= 3'd2)
        else $error("ok status with too few start codes");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(r_result))
        else $error("pending result overwritten");
`endif

endmodule

[verif/pscs_result_checker.sv]
// Result checker for the parameter-set start-code scanner testbench.
// Watches the config port and both streams, predicts each result beat and compares it.
// Depends on pscs_pkg.
module pscs_result_checker #(
    parameter int MAX_BYTES = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pscs_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic                           i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [111:0]                   i_m_tdata,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    pscs_pkg::t_cfg    cfg;
    pscs_pkg::t_result expected_results[$];

    int unsigned   scan_pos;
    logic [23:0]   tail;
    int unsigned   codes_taken;
    int unsigned   vps_from, vps_span;
    int unsigned   sps_from, sps_span;
    int unsigned   pps_from, pps_span;
    bit            overrun;

    initial begin
        o_pending    = 0;
        o_checked    = 0;
        o_fail_count = 0;
    end

    task automatic clear_scan();
        scan_pos    = 0;
        tail        = '0;
        codes_taken = 0;
        vps_from    = 0;
        vps_span    = 0;
        sps_from    = 0;
        sps_span    = 0;
        pps_from    = 0;
        pps_span    = 0;
        overrun     = 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // advance the scan by one byte; push the expected result on the final byte
    task automatic take_byte(input logic [7:0] b, input logic is_last);
        int unsigned       need;
        int unsigned       unit;
        int unsigned       p;
        pscs_pkg::t_result r;
        need = (cfg.codec_mode ? 3 : 2) + int'(cfg.pps_end_mode);
        if (!overrun) begin
            if (scan_pos >= MAX_BYTES) begin
                overrun = 1'b1;
            end else begin
                if (scan_pos >= 3 && tail == 24'h0 && b == 8'h01 && codes_taken < need) begin
                    unit = codes_taken + (cfg.codec_mode ? 0 : 1);
                    p    = scan_pos - 3;
                    case (unit)
                        0: vps_from = p + 4;
                        1: begin
                            if (cfg.codec_mode)
                                vps_span = p - vps_from;
                            sps_from = p + 4;
                        end
                        2: begin
                            sps_span = p - sps_from;
                            pps_from = p + 4;
                        end
                        default: pps_span = p - pps_from;
                    endcase
                    codes_taken++;
                    tail = '1;
                end else begin
                    tail = {tail[15:0], b};
                end
                scan_pos++;
            end
        end
        if (is_last) begin
            r = '0;
            if (overrun) begin
                r.status = pscs_pkg::ST_TOO_LONG;
            end else if (codes_taken < need) begin
                r.status      = pscs_pkg::ST_MISSING;
                r.codes_found = 3'(codes_taken);
            end else begin
                if (!cfg.pps_end_mode)
                    pps_span = scan_pos - pps_from;
                r.status      = pscs_pkg::ST_OK;
                r.codes_found = 3'(codes_taken);
                if (cfg.codec_mode) begin
                    r.vps_pos = vps_from[pscs_pkg::FIELD_W-1:0];
                    r.vps_len = vps_span[pscs_pkg::FIELD_W-1:0];
                end
                r.sps_pos = sps_from[pscs_pkg::FIELD_W-1:0];
                r.sps_len = sps_span[pscs_pkg::FIELD_W-1:0];
                r.pps_pos = pps_from[pscs_pkg::FIELD_W-1:0];
                r.pps_len = pps_span[pscs_pkg::FIELD_W-1:0];
            end
            expected_results.push_back(r);
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin
        pscs_pkg::t_result exp_r;
        if (!i_rst_n) begin
            cfg = '0;
            clear_scan();
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no result expected: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("status", exp_r.status, i_m_tdata[1:0]);
                    check_field("codes_found", exp_r.codes_found, i_m_tdata[4:2]);
                    check_field("vps_pos", exp_r.vps_pos, i_m_tdata[21:5]);
                    check_field("vps_len", exp_r.vps_len, i_m_tdata[38:22]);
                    check_field("sps_pos", exp_r.sps_pos, i_m_tdata[55:39]);
                    check_field("sps_len", exp_r.sps_len, i_m_tdata[72:56]);
                    check_field("pps_pos", exp_r.pps_pos, i_m_tdata[89:73]);
                    check_field("pps_len", exp_r.pps_len, i_m_tdata[106:90]);
                    o_checked++;
                end
            end
            if (i_cfg_we) begin
                case (pscs_pkg::t_cfg_idx'(i_cfg_addr))
                    pscs_pkg::CFG_CODEC_MODE:   cfg.codec_mode   = i_cfg_wdata;
                    pscs_pkg::CFG_PPS_END_MODE: cfg.pps_end_mode = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                take_byte(i_s_tdata, i_s_tlast);
        end
        o_pending = expected_results.size();
    end

endmodule

[verif/parameter_set_start_code_scanner_core_tb.sv]
// Testbench top for the parameter-set start-code scanner core.
// Drives Annex B buffers and config writes with random gaps and stalls; the verdict
// comes from pscs_result_checker. Depends on pscs_pkg and the core RTL.
module parameter_set_start_code_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES     = 65536;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BYTES  = 1480;
    localparam int PHASES        = 8;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [pscs_pkg::CFG_IDX_W-1:0] i_cfg_addr;
    logic                           i_cfg_wdata;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [7:0]                     i_s_tdata;
    logic                           i_s_tlast;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [111:0]                   o_m_tdata;

    int                   results_pending;
    int                   results_checked;
    int                   fail_count;
    int                   cycle_count;
    int                   bytes_sent;
    int                   buffers_sent;
    bit                   gaps_on;
    logic [7:0]           scan_buf[$];

    parameter_set_start_code_scanner_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    pscs_result_checker #(
        .MAX_BYTES (MAX_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_pending    (results_pending),
        .o_checked    (results_checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    // result side: after each accepted beat, stall at random while gaps are on
    initial begin
        int unsigned n;
        i_m_tready = 1'b1;
        forever begin
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
            @(negedge i_clk);
            n = gaps_on ? $urandom_range(0, 7) : 0;
            if (n != 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        foreach (scan_buf[i])
            send_byte(scan_buf[i], i == scan_buf.size() - 1);
        buffers_sent++;
    endtask

    // hold the byte stream until every expected result beat has come back
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input pscs_pkg::t_cfg_idx idx, input logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_modes(input logic codec, input logic pps_end);
        drain();
        write_reg(pscs_pkg::CFG_CODEC_MODE, codec);
        write_reg(pscs_pkg::CFG_PPS_END_MODE, pps_end);
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 8'h00;
        if (r == 3)
            return 8'h01;
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly well-formed unit sequences, some broken codes and some pure noise
    task automatic make_buffer(input int unsigned need);
        int unsigned n_codes;
        int unsigned n_pay;
        int unsigned spoil;
        scan_buf.delete();
        if ($urandom_range(0, 9) < 7) begin
            n_codes = $urandom_range(need - 1, need + 1);
            repeat ($urandom_range(0, 3)) scan_buf.push_back(pick_byte());
            repeat (n_codes) begin
                spoil = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
                for (int unsigned k = 0; k < 4; k++)
                    scan_buf.push_back(k == spoil ? 8'($urandom_range(0, 255))
                                                  : (k == 3 ? 8'h01 : 8'h00));
                n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30)
                                                    : $urandom_range(0, 6);
                repeat (n_pay) scan_buf.push_back(pick_byte());
            end
        end else begin
            repeat ($urandom_range(1, 24)) scan_buf.push_back(pick_byte());
        end
    endtask

    initial begin
        int phase_bytes;
        logic codec;
        logic pps_end;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = pscs_pkg::CFG_CODEC_MODE;
        i_cfg_wdata  = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 8'h00;
        i_s_tlast    = 1'b0;
        gaps_on      = 1'b1;
        bytes_sent   = 0;
        buffers_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset modes: H.264, PPS to buffer end
        scan_buf = '{8'hFF};
        send_buffer();
        scan_buf = '{8'h00, 8'h00, 8'h01};
        send_buffer();
        scan_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h01, 8'h68, 8'hFF};
        send_buffer();
        set_modes(1'b1, 1'b1);
        scan_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h40, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'h00, 8'h00, 8'h00, 8'h01};
        send_buffer();

        for (int ph = 0; ph < PHASES; ph++) begin
            codec   = ph[0];
            pps_end = ph[1];
            set_modes(codec, pps_end);
            gaps_on     = (ph % 3) != 2;
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < RANDOM_BYTES / PHASES) begin
                make_buffer((codec ? 3 : 2) + int'(pps_end));
                send_buffer();
            end
        end

        drain();
        repeat (4) @(negedge i_clk);
        $display("Sent %0d bytes in %0d buffers over all four mode settings,", bytes_sent,
                 buffers_sent);
        $display("with and without random gaps and stalls; %0d result beats checked.",
                 results_checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
